// ===== hw/rtl/differential_drive_odometry_unit_assert.svh =====
// Assertion macros for the differential drive odometry unit.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ODO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry assertion failed");
`define ODO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry assertion failed");
`else
`define ODO_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ODO_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/odo_pkg.sv =====
// Shared types, constants and helper functions for the odometry unit.
package odo_pkg;

    localparam int SPEED_W = 16;
    localparam int POS_W   = 48;
    localparam int ACC_W   = 52;
    localparam int ANG_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W  = 16;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CV_W    = 34;
    localparam int CZ_W    = 33;
    localparam int Q15_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

    localparam logic [31:0]       RST_TURN_GAIN     = 32'd48273920;
    localparam logic [STEP_W-1:0] RST_STEP_TIME     = 16'd2621;
    localparam logic [ANG_W-1:0]  RST_START_HEADING = 32'd3937053355;

    localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MP,
        S_MD,
        S_CORD,
        S_MC,
        S_MS,
        S_ACY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    done;
        logic signed [Q15_W-1:0] cos_val;
        logic signed [Q15_W-1:0] sin_val;
    } t_trig;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CV_W-1:0] v);
        logic signed [CV_W-1:0] t;
        logic signed [Q15_W-1:0] r;
        t = (v + CV_W'(16384)) >>> 15;
        if (t > CV_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (t < -CV_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = t[Q15_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0]  rnd;
        logic signed [35:0]      inc;
        logic signed [ACC_W:0]   sum;
        logic signed [ACC_W-1:0] r;
        rnd = {prod[PROD_W-1], prod} + (PROD_W+1)'(16384);
        inc = rnd[PROD_W:15];
        sum = {acc[ACC_W-1], acc} + {{(ACC_W-35){inc[35]}}, inc};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            r = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = sum[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/odo_in_if.sv =====
// Request channel carrying wheel speeds and the restart flag.
interface odo_in_if;
    import odo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] left_speed;
    logic                      restart;

    modport source (output valid, output right_speed, output left_speed, output restart,
                    input ready);
    modport sink (input valid, input right_speed, input left_speed, input restart,
                  output ready);
endinterface

// ===== hw/rtl/odo_out_if.sv =====
// Result channel carrying the updated x and y position.
interface odo_out_if;
    import odo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] y_position;

    modport source (output valid, output x_position, output y_position, input ready);
    modport sink (input valid, input x_position, input y_position, output ready);
endinterface

// ===== hw/rtl/odo_mul.sv =====
// Shared signed multiplier with a registered product.
module odo_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [odo_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [odo_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [odo_pkg::PROD_W-1:0]   o_prod
);
    import odo_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;
endmodule

// ===== hw/rtl/odo_cordic.sv =====
// Iterative rotation CORDIC giving Q1.15 cosine and sine of a binary angle.
module odo_cordic #(
    parameter int TRIG_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [odo_pkg::ANG_W-1:0] i_angle,
    output odo_pkg::t_trig            o_trig
);
    import odo_pkg::*;

    localparam int CNT_W = $clog2(TRIG_BITS);
    localparam logic [ANG_W-1:0] ANG_MASK = ~((32'd1 << (ANG_W - TRIG_BITS)) - 32'd1);
    localparam logic [1:0] QD_FIRST  = 2'd0;
    localparam logic [1:0] QD_SECOND = 2'd1;
    localparam logic [1:0] QD_THIRD  = 2'd2;
    localparam logic [1:0] QD_FOURTH = 2'd3;

    logic signed [CV_W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [CZ_W-1:0]  r_z, n_z;
    logic [1:0]              r_quad;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic signed [Q15_W-1:0] r_cos_q, r_sin_q;
    logic [ANG_W-1:0]        w_ang;
    logic signed [CV_W-1:0]  w_xs, w_ys, w_c, w_s;
    logic signed [CZ_W-1:0]  w_atan;

    assign w_ang  = i_angle & ANG_MASK;
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_atan = {1'b0, atan_lut(5'(r_cnt))};

    always_comb begin
        if (!r_z[CZ_W-1]) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_atan;
        end
    end

    always_comb begin
        case (r_quad)
            QD_FIRST: begin
                w_c = r_x;
                w_s = r_y;
            end
            QD_SECOND: begin
                w_c = -r_y;
                w_s = r_x;
            end
            QD_THIRD: begin
                w_c = -r_x;
                w_s = -r_y;
            end
            QD_FOURTH: begin
                w_c = r_y;
                w_s = -r_x;
            end
            default: begin
                w_c = r_x;
                w_s = r_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(TRIG_BITS - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {3'b000, w_ang[29:0]};
            r_quad <= w_ang[31:30];
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_fin) begin
            r_cos_q <= to_q15(w_c);
            r_sin_q <= to_q15(w_s);
        end
    end

    assign o_trig = '{r_done, r_cos_q, r_sin_q};
endmodule

// ===== hw/rtl/differential_drive_odometry_unit.sv =====
// Top level of the differential drive odometry unit.
// Each request carries right and left wheel speeds and a restart flag and yields one
// result with the new x and y position. The time from acceptance to result is set by
// the CORDIC, which resolves one bit of angle per cycle, and by four passes through
// the single shared multiplier for heading change, distance and the two position
// increments. The unit takes no new request until the current one has reached the
// output register, which holds it until it is taken. Configuration writes take
// effect at once; a new start heading is used at the next restart.
`include "differential_drive_odometry_unit_assert.svh"
module differential_drive_odometry_unit #(
    parameter int TRIG_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odo_pkg::CFG_W-1:0]     i_cfg_data,
    odo_in_if.sink                        i_req,
    odo_out_if.source                     o_rsp
);
    import odo_pkg::*;

    t_state r_state, n_state;

    logic [31:0]              r_turn_gain;
    logic [STEP_W-1:0]        r_step_time;
    logic [ANG_W-1:0]         r_start_heading;
    logic [ANG_W-1:0]         r_heading;
    logic signed [ACC_W-1:0]  r_x_acc, r_y_acc;
    logic signed [SPEED_W-1:0] r_right, r_left;
    logic signed [31:0]       r_dist;
    logic signed [Q15_W-1:0]  r_cos, r_sin;
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_x_out, r_y_out;

    logic                        w_in_acc;
    logic                        w_out_free;
    logic                        w_mul_en;
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]    w_prod;
    logic                        w_trig_start;
    logic [ANG_W-1:0]            w_mid;
    t_trig                       w_trig;
    logic signed [MUL_B_W-1:0]   w_diff, w_sum;

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_diff     = {r_right[SPEED_W-1], r_right} - {r_left[SPEED_W-1], r_left};
    assign w_sum      = {r_right[SPEED_W-1], r_right} + {r_left[SPEED_W-1], r_left};
    assign w_mid      = r_heading + w_prod[44:13];

    odo_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    odo_cordic #(
        .TRIG_BITS (TRIG_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_trig_start),
        .i_angle (w_mid),
        .o_trig  (w_trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_mul_en     = 1'b0;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_trig_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_MP;
                end
            end
            S_MP: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_turn_gain};
                w_mul_b  = w_diff;
                n_state  = S_MD;
            end
            S_MD: begin
                w_mul_en     = 1'b1;
                w_mul_a      = {{(MUL_A_W-STEP_W){1'b0}}, r_step_time};
                w_mul_b      = w_sum;
                w_trig_start = 1'b1;
                n_state      = S_CORD;
            end
            S_CORD: begin
                if (w_trig.done) begin
                    n_state = S_MC;
                end
            end
            S_MC: begin
                w_mul_en = 1'b1;
                w_mul_a  = {r_dist[31], r_dist};
                w_mul_b  = {r_cos[Q15_W-1], r_cos};
                n_state  = S_MS;
            end
            S_MS: begin
                w_mul_en = 1'b1;
                w_mul_a  = {r_dist[31], r_dist};
                w_mul_b  = {r_sin[Q15_W-1], r_sin};
                n_state  = S_ACY;
            end
            S_ACY: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain     <= RST_TURN_GAIN;
            r_step_time     <= RST_STEP_TIME;
            r_start_heading <= RST_START_HEADING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TURN_GAIN:     r_turn_gain     <= i_cfg_data;
                CFG_STEP_TIME:     r_step_time     <= i_cfg_data[STEP_W-1:0];
                CFG_START_HEADING: r_start_heading <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= RST_START_HEADING;
            r_x_acc   <= '0;
            r_y_acc   <= '0;
        end else begin
            if (w_in_acc && i_req.restart) begin
                r_heading <= r_start_heading;
                r_x_acc   <= '0;
                r_y_acc   <= '0;
            end
            if (r_state == S_MD) begin
                r_heading <= r_heading + w_prod[43:12];
            end
            if (r_state == S_MS) begin
                r_x_acc <= sat_add(r_x_acc, w_prod);
            end
            if (r_state == S_ACY) begin
                r_y_acc <= sat_add(r_y_acc, w_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_right <= i_req.right_speed;
            r_left  <= i_req.left_speed;
        end
        if (r_state == S_CORD && w_trig.done) begin
            r_dist <= w_prod[32:1];
            r_cos  <= w_trig.cos_val;
            r_sin  <= w_trig.sin_val;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_x_out <= r_x_acc[ACC_W-1:ACC_W-POS_W];
            r_y_out <= r_y_acc[ACC_W-1:ACC_W-POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.x_position = r_x_out;
    assign o_rsp.y_position = r_y_out;

    `ODO_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == S_MP)
    `ODO_ASSERT_IMP(a_trig_in_wait, i_clk, i_rst_n, w_trig.done, r_state == S_CORD)
    `ODO_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, r_state == S_DONE && w_out_free, r_out_valid)
endmodule

// ===== verif/odometry_pose_check.sv =====
`timescale 1ns / 100ps
// Pose predictor and result checker that watches the odometry unit's channels.
module odometry_pose_check #(
    parameter int TRIG_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odo_pkg::CFG_W-1:0]     i_cfg_data,
    odo_in_if                             i_req,
    odo_out_if                            i_rsp,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_checked
);
    import odo_pkg::*;

    localparam longint ACC_HI = 64'sh0007_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 64'sd1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } pose_xy_t;

    logic [31:0] arctan_tab [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic [ANG_W-1:0]  gain_q12;
    logic [STEP_W-1:0] step_q16;
    logic [ANG_W-1:0]  start_ang;
    logic [ANG_W-1:0]  heading;
    longint            x_acc;
    longint            y_acc;
    pose_xy_t          pose_q [$];

    function automatic longint round_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end else if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r;
    endfunction

    function automatic void mid_trig(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        int          i;
        a = ang & ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
        z = longint'(a[29:0]);
        x = 64'sd652032874;
        y = 64'sd0;
        for (i = 0; i < TRIG_BITS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(arctan_tab[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(arctan_tab[i]);
            end
            x = nx;
        end
        case (a[31:30])
            2'd0: begin
                c = x;
                s = y;
            end
            2'd1: begin
                c = -y;
                s = x;
            end
            2'd2: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        c = round_to_q15(c);
        s = round_to_q15(s);
    endfunction

    function automatic longint acc_add(input longint acc, input longint inc);
        longint r;
        r = acc + inc;
        if (r > ACC_HI) begin
            r = ACC_HI;
        end else if (r < ACC_LO) begin
            r = ACC_LO;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        longint      r;
        longint      l;
        longint      p;
        longint      d;
        longint      c;
        longint      s;
        logic [31:0] mid;
        pose_xy_t    want;
        if (!i_rst_n) begin
            gain_q12     = 32'd48273920;
            step_q16     = 16'd2621;
            start_ang    = 32'd3937053355;
            heading      = 32'd3937053355;
            x_acc        = 64'sd0;
            y_acc        = 64'sd0;
            o_mismatches = 0;
            o_checked    = 0;
            pose_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TURN_GAIN:     gain_q12 = i_cfg_data;
                    CFG_STEP_TIME:     step_q16 = i_cfg_data[STEP_W-1:0];
                    CFG_START_HEADING: start_ang = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: result with no request pending: x=%0d y=%0d",
                             $time, i_rsp.x_position, i_rsp.y_position);
                    o_mismatches++;
                end else begin
                    want = pose_q.pop_front();
                    o_checked++;
                    if (i_rsp.x_position !== want.x) begin
                        $display("%0t: x_position expected %0d got %0d",
                                 $time, want.x, i_rsp.x_position);
                        o_mismatches++;
                    end
                    if (i_rsp.y_position !== want.y) begin
                        $display("%0t: y_position expected %0d got %0d",
                                 $time, want.y, i_rsp.y_position);
                        o_mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                r = longint'(i_req.right_speed);
                l = longint'(i_req.left_speed);
                if (i_req.restart) begin
                    heading = start_ang;
                    x_acc   = 64'sd0;
                    y_acc   = 64'sd0;
                end
                p       = (r - l) * longint'(gain_q12);
                mid     = heading + 32'(p >>> 13);
                heading = heading + 32'(p >>> 12);
                d       = ((r + l) * longint'(step_q16)) >>> 1;
                mid_trig(mid, c, s);
                x_acc  = acc_add(x_acc, (d * c + 64'sd16384) >>> 15);
                y_acc  = acc_add(y_acc, (d * s + 64'sd16384) >>> 15);
                want.x = POS_W'(x_acc >>> 4);
                want.y = POS_W'(y_acc >>> 4);
                pose_q.push_back(want);
            end
        end
        o_pending = pose_q.size();
    end

endmodule

// ===== verif/tb_differential_drive_odometry_unit.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the odometry unit: clock, reset, stimulus and verdict.
module tb_differential_drive_odometry_unit;
    import odo_pkg::*;

    localparam int TRIG_BITS          = 16;
    localparam int HOLD_CYCLES        = 160;
    localparam int STALL_LIMIT        = 2000;
    localparam int STEPS_PER_SETTING  = 212;
    localparam int SETTING_COUNT      = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatches;
    int pending;
    int checked;
    int send_gap_max = 9;
    int rx_stall_max = 9;
    bit rx_hold = 1'b0;
    int restarts_sent = 0;
    int settings_run = 0;
    int quiet_cycles = 0;

    odo_in_if  req_if ();
    odo_out_if rsp_if ();

    differential_drive_odometry_unit #(
        .TRIG_BITS(TRIG_BITS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if),
        .o_rsp     (rsp_if)
    );

    odometry_pose_check #(
        .TRIG_BITS(TRIG_BITS)
    ) u_pose_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (rx_hold) begin
                stall   = HOLD_CYCLES;
                rx_hold = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_if.valid && rsp_if.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_step(input logic signed [SPEED_W-1:0] right,
                             input logic signed [SPEED_W-1:0] left, input logic restart);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.right_speed <= right;
        req_if.left_speed  <= left;
        req_if.restart     <= restart;
        if (restart) restarts_sent++;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_step();
        logic signed [SPEED_W-1:0] right;
        logic signed [SPEED_W-1:0] left;
        case ($urandom_range(0, 3))
            0: begin
                right = 16'($urandom);
                left  = 16'($urandom);
            end
            1: begin
                right = 16'($urandom_range(0, 400) - 200);
                left  = 16'($urandom_range(0, 400) - 200);
            end
            2: begin
                right = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                left  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default: begin
                right = 16'($urandom);
                left  = right;
            end
        endcase
        send_step(right, left, $urandom_range(0, 29) == 0);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] gain, input logic [STEP_W-1:0] step,
                                 input logic [ANG_W-1:0] start_ang);
        drain();
        cfg_write(CFG_TURN_GAIN, gain);
        cfg_write(CFG_STEP_TIME, {16'($urandom), step});
        cfg_write(CFG_START_HEADING, start_ang);
        cfg_write(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        int k;
        int q;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.right_speed <= '0;
        req_if.left_speed  <= '0;
        req_if.restart     <= 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: speed extremes, spins both ways, standstill.
        send_step(16'sd100, 16'sd100, 1'b1);
        send_step(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_step(16'sh8000, 16'sh8000, 1'b0);
        send_step(16'sh7FFF, 16'sh8000, 1'b0);
        send_step(16'sh8000, 16'sh7FFF, 1'b0);
        send_step(16'sd0, 16'sd0, 1'b0);
        send_step(16'sd1, -16'sd1, 1'b0);
        send_step(-16'sd1, 16'sd1, 1'b1);

        // The new start heading must not apply until the restart that follows.
        apply_setting(32'd0, 16'hFFFF, 32'd0);
        send_step(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_step(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_step(16'sh8000, 16'sh8000, 1'b0);
        send_step(16'sh7FFF, 16'sh7FFF, 1'b0);

        // Largest gain makes the heading wrap repeatedly.
        apply_setting(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_step(16'sh7FFF, 16'sh8000, 1'b1);
        send_step(16'sh8000, 16'sh7FFF, 1'b0);
        send_step(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_step(16'sh8000, 16'sh8000, 1'b0);

        for (q = 0; q < 4; q++) begin
            apply_setting(32'd0, 16'd40000, {2'(q), 30'd0});
            send_step(16'sd20000, 16'sd20000, 1'b1);
        end

        for (k = 0; k < SETTING_COUNT; k++) begin
            case (k)
                0: apply_setting(32'd48273920, 16'd2621, 32'd3937053355);
                1: apply_setting(32'd0, 16'hFFFF, 32'd0);
                2: apply_setting(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
                3: apply_setting($urandom, 16'($urandom), $urandom);
                4: apply_setting($urandom_range(0, 32'h0010_0000), 16'($urandom), $urandom);
                default: apply_setting(32'd48273920, 16'hFFFF, $urandom);
            endcase
            case (k % 3)
                0: begin
                    send_gap_max = 9;
                    rx_stall_max = 9;
                end
                1: begin
                    send_gap_max = 0;
                    rx_stall_max = 9;
                end
                default: begin
                    send_gap_max = 9;
                    rx_stall_max = 0;
                end
            endcase
            if (k == 4) begin
                rx_stall_max = 0;
            end
            if (k == 1 || k == 4) begin
                rx_hold = 1'b1;
            end
            repeat (STEPS_PER_SETTING) send_random_step();
        end

        drain();
        repeat (40) @(negedge i_clk);
        $display("Checked %0d position updates, %0d of them after a restart, over %0d settings.",
                 checked, restarts_sent, settings_run);
        $display("Gaps and result stalls of 0 to 9 cycles, plus a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
